[hw/rtl/rmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    // Fixed-point format of every rotation and quaternion value
    localparam int FRAC_BITS = 29;

    // Field and bus widths
    localparam int WORD_W  = 32;
    localparam int IN_W    = 12 * WORD_W;
    localparam int OUT_W   = 7 * WORD_W;
    localparam int TRANS_W = 3 * WORD_W;

    // Trace and root argument: exact sums of 32-bit terms
    localparam int TRACE_W = WORD_W + 2;
    localparam int ARG_W   = WORD_W + 3;
    localparam int POS_W   = WORD_W + 1;   // a positive argument stays below 2^33
    localparam int NUM_W   = WORD_W + 1;   // off-diagonal sum or difference

    // Square root of (arg << FRAC_BITS), one root bit per stage
    localparam int RAD_W     = POS_W + FRAC_BITS;
    localparam int ROOT_W    = (RAD_W + 1) / 2;
    localparam int RAD_PAD   = 2 * ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 3;

    // Division (mag << FRAC_BITS) / S, one quotient bit per stage
    localparam int S_W   = ROOT_W + 1;
    localparam int Q_W   = WORD_W;
    localparam int SH    = WORD_W - FRAC_BITS;

    localparam logic signed [ARG_W-1:0] ARG_ONE = ARG_W'(64'd1 << FRAC_BITS);
    localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

    // Quaternion component that carries the S/4 term
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_W = 2'd3;

    typedef logic signed [NUM_W-1:0] num_t;

    // Entry stage: branch chosen, argument and numerators formed
    typedef struct packed {
        logic [TRANS_W-1:0]       trans;
        logic [1:0]               comp;
        num_t [2:0]               num;
        logic signed [ARG_W-1:0]  arg;
    } pre_t;

    // Square-root stage
    typedef struct packed {
        logic [TRANS_W-1:0]   trans;
        logic [1:0]           comp;
        num_t [2:0]           num;
        logic [RAD_PAD-1:0]   rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [ROOT_W-1:0]    root;
    } sq_t;

    // One divider lane
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [S_W-1:0]    rem;
        logic [Q_W-1:0]    q;
        logic [WORD_W-1:0] dlow;
    } dv_lane_t;

    // Division stage
    typedef struct packed {
        logic [TRANS_W-1:0]  trans;
        logic [1:0]          comp;
        logic [WORD_W-1:0]   quarter;
        logic [S_W-1:0]      s;
        dv_lane_t [2:0]      lane;
    } dv_t;

endpackage

`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields (lowest bits first)
// s_*      in   tdata: trans_x, trans_y, trans_z, rot_00 .. rot_22 (32 b each)
// m_*      out  tdata: pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w (32 b each)
//
// One transform per cycle while the skid register is free; the pipeline is an entry
// stage, ROOT_W bit-per-stage square-root stages, a divider setup stage and Q_W
// bit-per-stage stages of the three dividers, then the output register.
// aresetn (synchronous) clears all valid bits, those of the output/skid registers included.
// A stalled output fills the skid register, then freezes the whole pipeline.
module rotation_matrix_to_quaternion (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rmq_pkg::IN_W-1:0]    s_tdata,   // trans_x,y,z, rot_00..rot_22
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [rmq_pkg::OUT_W-1:0]        m_tdata    // pos_x,y,z, quat_x,y,z,w
);
    import rmq_pkg::*;

    logic en;

    pre_t                pre_reg, pre_next;
    logic                pre_vld_reg;
    sq_t                 sq_reg [0:ROOT_W-1];
    logic                sq_vld_reg [0:ROOT_W-1];
    dv_t                 dp_reg, dp_next;
    logic                dp_vld_reg;
    dv_t                 dv_reg [0:Q_W-1];
    logic                dv_vld_reg [0:Q_W-1];

    logic [OUT_W-1:0]    res_next;
    logic [OUT_W-1:0]    out_reg, skid_reg;
    logic                out_vld_reg, skid_vld_reg;

    // Advance the whole pipeline while the skid register is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Entry: trace, branch choice, root argument and numerators
    always_comb begin
        logic signed [WORD_W-1:0]  r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic signed [TRACE_W-1:0] trace;
        r00 = s_tdata[3*WORD_W +: WORD_W];
        r01 = s_tdata[4*WORD_W +: WORD_W];
        r02 = s_tdata[5*WORD_W +: WORD_W];
        r10 = s_tdata[6*WORD_W +: WORD_W];
        r11 = s_tdata[7*WORD_W +: WORD_W];
        r12 = s_tdata[8*WORD_W +: WORD_W];
        r20 = s_tdata[9*WORD_W +: WORD_W];
        r21 = s_tdata[10*WORD_W +: WORD_W];
        r22 = s_tdata[11*WORD_W +: WORD_W];
        trace = TRACE_W'(r00) + TRACE_W'(r11) + TRACE_W'(r22);
        pre_next.trans = s_tdata[TRANS_W-1:0];
        if (trace > 0) begin
            pre_next.comp   = COMP_W;
            pre_next.arg    = ARG_W'(trace) + ARG_ONE;
            pre_next.num[0] = NUM_W'(r21) - NUM_W'(r12);
            pre_next.num[1] = NUM_W'(r02) - NUM_W'(r20);
            pre_next.num[2] = NUM_W'(r10) - NUM_W'(r01);
        end else if (r00 > r11 && r00 > r22) begin
            pre_next.comp   = COMP_X;
            pre_next.arg    = ARG_ONE + ARG_W'(r00) - ARG_W'(r11) - ARG_W'(r22);
            pre_next.num[0] = NUM_W'(r01) + NUM_W'(r10);
            pre_next.num[1] = NUM_W'(r02) + NUM_W'(r20);
            pre_next.num[2] = NUM_W'(r21) - NUM_W'(r12);
        end else if (r11 > r22) begin
            pre_next.comp   = COMP_Y;
            pre_next.arg    = ARG_ONE + ARG_W'(r11) - ARG_W'(r00) - ARG_W'(r22);
            pre_next.num[0] = NUM_W'(r01) + NUM_W'(r10);
            pre_next.num[1] = NUM_W'(r12) + NUM_W'(r21);
            pre_next.num[2] = NUM_W'(r02) - NUM_W'(r20);
        end else begin
            pre_next.comp   = COMP_Z;
            pre_next.arg    = ARG_ONE + ARG_W'(r22) - ARG_W'(r00) - ARG_W'(r11);
            pre_next.num[0] = NUM_W'(r02) + NUM_W'(r20);
            pre_next.num[1] = NUM_W'(r12) + NUM_W'(r21);
            pre_next.num[2] = NUM_W'(r10) - NUM_W'(r01);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg <= 1'b0;
        end else if (en) begin
            pre_vld_reg <= s_tvalid;
        end
        if (en) begin
            pre_reg <= pre_next;
        end
    end

    // Square root: one root bit per stage
    genvar gi;
    generate
        for (gi = 0; gi < ROOT_W; gi++) begin : g_sq
            sq_t                 sq_in, sq_next;
            logic                vld_in;
            logic [SQ_REM_W-1:0] rem2, trial;

            if (gi == 0) begin : g_first
                always_comb begin
                    sq_in.trans = pre_reg.trans;
                    sq_in.comp  = pre_reg.comp;
                    sq_in.num   = pre_reg.num;
                    sq_in.rad   = (pre_reg.arg > 0) ?
                        RAD_PAD'({pre_reg.arg[POS_W-1:0], {FRAC_BITS{1'b0}}}) : '0;
                    sq_in.rem   = '0;
                    sq_in.root  = '0;
                end
                assign vld_in = pre_vld_reg;
            end else begin : g_rest
                assign sq_in  = sq_reg[gi-1];
                assign vld_in = sq_vld_reg[gi-1];
            end

            always_comb begin
                rem2  = {sq_in.rem[SQ_REM_W-3:0], sq_in.rad[RAD_PAD-1 -: 2]};
                trial = SQ_REM_W'({sq_in.root, 2'b01});
                sq_next       = sq_in;
                sq_next.rad   = {sq_in.rad[RAD_PAD-3:0], 2'b00};
                if (rem2 >= trial) begin
                    sq_next.rem  = rem2 - trial;
                    sq_next.root = {sq_in.root[ROOT_W-2:0], 1'b1};
                end else begin
                    sq_next.rem  = rem2;
                    sq_next.root = {sq_in.root[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq_vld_reg[gi] <= 1'b0;
                end else if (en) begin
                    sq_vld_reg[gi] <= vld_in;
                end
                if (en) begin
                    sq_reg[gi] <= sq_next;
                end
            end
        end
    endgenerate

    // Divider setup: S, S/4, magnitudes and overflow test
    always_comb begin
        logic [ROOT_W-1:0]  root;
        logic [S_W-1:0]     s;
        logic signed [NUM_W-1:0] n;
        logic [NUM_W-1:0]   mag;
        root = sq_reg[ROOT_W-1].root;
        s    = {root, 1'b0};
        n    = '0;
        mag  = '0;
        dp_next.trans   = sq_reg[ROOT_W-1].trans;
        dp_next.comp    = sq_reg[ROOT_W-1].comp;
        dp_next.quarter = WORD_W'(root >> 1);
        // Zero S: nonzero numerators saturate, zero ones divide by one to give zero
        dp_next.s       = (root == '0) ? S_W'(1) : s;
        for (int l = 0; l < 3; l++) begin
            n   = sq_reg[ROOT_W-1].num[l];
            mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
            dp_next.lane[l].neg  = n[NUM_W-1];
            dp_next.lane[l].ovf  = (mag != '0) && (S_W'(mag >> SH) >= s ||
                                   (mag >> SH) > NUM_W'(s));
            dp_next.lane[l].rem  = S_W'(mag >> SH);
            dp_next.lane[l].q    = '0;
            dp_next.lane[l].dlow = {mag[SH-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_vld_reg <= 1'b0;
        end else if (en) begin
            dp_vld_reg <= sq_vld_reg[ROOT_W-1];
        end
        if (en) begin
            dp_reg <= dp_next;
        end
    end

    // Division: one quotient bit per stage in each of three lanes
    generate
        for (gi = 0; gi < Q_W; gi++) begin : g_dv
            dv_t  dv_in, dv_next;
            logic vld_in;

            if (gi == 0) begin : g_first
                assign dv_in  = dp_reg;
                assign vld_in = dp_vld_reg;
            end else begin : g_rest
                assign dv_in  = dv_reg[gi-1];
                assign vld_in = dv_vld_reg[gi-1];
            end

            always_comb begin
                logic [S_W:0] rem2;
                rem2    = '0;
                dv_next = dv_in;
                for (int l = 0; l < 3; l++) begin
                    rem2 = {dv_in.lane[l].rem, dv_in.lane[l].dlow[WORD_W-1]};
                    dv_next.lane[l].dlow = {dv_in.lane[l].dlow[WORD_W-2:0], 1'b0};
                    if (rem2 >= (S_W+1)'(dv_in.s)) begin
                        dv_next.lane[l].rem = S_W'(rem2 - (S_W+1)'(dv_in.s));
                        dv_next.lane[l].q   = {dv_in.lane[l].q[Q_W-2:0], 1'b1};
                    end else begin
                        dv_next.lane[l].rem = rem2[S_W-1:0];
                        dv_next.lane[l].q   = {dv_in.lane[l].q[Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_vld_reg[gi] <= 1'b0;
                end else if (en) begin
                    dv_vld_reg[gi] <= vld_in;
                end
                if (en) begin
                    dv_reg[gi] <= dv_next;
                end
            end
        end
    endgenerate

    // Saturate quotients and place the S/4 term on its component
    always_comb begin
        logic [WORD_W-1:0] val [0:2];
        logic [WORD_W-1:0] comp_val [0:3];
        dv_lane_t          ln;
        for (int l = 0; l < 3; l++) begin
            ln = dv_reg[Q_W-1].lane[l];
            if (ln.ovf) begin
                val[l] = ln.neg ? Q_MIN : Q_MAX;
            end else if (ln.neg) begin
                val[l] = ln.q[Q_W-1] ? Q_MIN : WORD_W'(-ln.q);
            end else begin
                val[l] = ln.q[Q_W-1] ? Q_MAX : ln.q;
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (2'(k) == dv_reg[Q_W-1].comp) begin
                comp_val[k] = dv_reg[Q_W-1].quarter;
            end else if (2'(k) < dv_reg[Q_W-1].comp) begin
                comp_val[k] = val[k];
            end else begin
                comp_val[k] = val[k-1];
            end
        end
        res_next = {comp_val[COMP_W], comp_val[COMP_Z], comp_val[COMP_Y],
                    comp_val[COMP_X], dv_reg[Q_W-1].trans};
    end

    // Output register with skid register behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (dv_vld_reg[Q_W-1]) begin
            if (out_vld_reg && !m_tready) begin
                skid_vld_reg <= 1'b1;
            end
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (dv_vld_reg[Q_W-1]) begin
            if (out_vld_reg && !m_tready) begin
                skid_reg <= res_next;
            end else begin
                out_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // Skid holds data only behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full with empty output register");

    // Skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid register filled without a stall");

    // Restoring divider keeps each live remainder below S
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[Q_W-1] |->
            (dv_reg[Q_W-1].lane[0].ovf || dv_reg[Q_W-1].lane[0].rem < dv_reg[Q_W-1].s) &&
            (dv_reg[Q_W-1].lane[1].ovf || dv_reg[Q_W-1].lane[1].rem < dv_reg[Q_W-1].s) &&
            (dv_reg[Q_W-1].lane[2].ovf || dv_reg[Q_W-1].lane[2].rem < dv_reg[Q_W-1].s))
        else $error("divider remainder not below divisor");

    // Square-root remainder never exceeds twice the root
    a_sq_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg[ROOT_W-1] |->
            sq_reg[ROOT_W-1].rem <= SQ_REM_W'({sq_reg[ROOT_W-1].root, 1'b0}))
        else $error("square-root remainder out of range");

endmodule

`default_nettype wire

[sim/tb_rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int N_RANDOM  = 1250;
    localparam int LATENCY   = 66;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [WORD_W-1:0] qw;
        logic [WORD_W-1:0] qz;
        logic [WORD_W-1:0] qy;
        logic [WORD_W-1:0] qx;
        logic [WORD_W-1:0] pz;
        logic [WORD_W-1:0] py;
        logic [WORD_W-1:0] px;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // transform queue; an all-zero entry flagged in drain_q asks the driver to drain first
    logic [IN_W-1:0] xform_q[$];
    bit              drain_q[$];
    pose_t           pose_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  n_sent = 0;
    int  n_recv = 0;
    int  n_branch[4];
    bit  stim_done = 0;

    rotation_matrix_to_quaternion u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(sqrt(arg << FRAC_BITS)), bit by bit
    function automatic longint root_of(longint arg);
        logic [63:0] n, r, b;
        if (arg <= 0) return 0;
        n = 64'(arg) << FRAC_BITS;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= n) r = b;
        end
        return longint'(r);
    endfunction

    function automatic longint quotient(longint num, longint s);
        logic [63:0] mag, q;
        if (s <= 0) begin
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = (mag << FRAC_BITS) / 64'(s);
        if (num < 0) return (q >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic pose_t pose_of(logic [IN_W-1:0] d);
        longint r[9];
        longint one, tr, s, qtr, qx, qy, qz, qw;
        pose_t p;
        one = longint'(1) << FRAC_BITS;
        for (int i = 0; i < 9; i++) r[i] = longint'($signed(d[(i+3)*WORD_W +: WORD_W]));
        tr = r[0] + r[4] + r[8];
        if (tr > 0) begin
            s = 2 * root_of(tr + one);
            qtr = sat_word(s >>> 2);
            qw = qtr;
            qx = quotient(r[7] - r[5], s);
            qy = quotient(r[2] - r[6], s);
            qz = quotient(r[3] - r[1], s);
            n_branch[COMP_W]++;
        end else if (r[0] > r[4] && r[0] > r[8]) begin
            s = 2 * root_of(one + r[0] - r[4] - r[8]);
            qx = sat_word(s >>> 2);
            qw = quotient(r[7] - r[5], s);
            qy = quotient(r[1] + r[3], s);
            qz = quotient(r[2] + r[6], s);
            n_branch[COMP_X]++;
        end else if (r[4] > r[8]) begin
            s = 2 * root_of(one + r[4] - r[0] - r[8]);
            qy = sat_word(s >>> 2);
            qw = quotient(r[2] - r[6], s);
            qx = quotient(r[1] + r[3], s);
            qz = quotient(r[5] + r[7], s);
            n_branch[COMP_Y]++;
        end else begin
            s = 2 * root_of(one + r[8] - r[0] - r[4]);
            qz = sat_word(s >>> 2);
            qw = quotient(r[3] - r[1], s);
            qx = quotient(r[2] + r[6], s);
            qy = quotient(r[5] + r[7], s);
            n_branch[COMP_Z]++;
        end
        p.px = d[0 +: WORD_W];
        p.py = d[WORD_W +: WORD_W];
        p.pz = d[2*WORD_W +: WORD_W];
        p.qx = qx[WORD_W-1:0];
        p.qy = qy[WORD_W-1:0];
        p.qz = qz[WORD_W-1:0];
        p.qw = qw[WORD_W-1:0];
        return p;
    endfunction

    function automatic logic [IN_W-1:0] pack_xform(logic [31:0] t[3], logic [31:0] m[9]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 3; i++) d[i*WORD_W +: WORD_W] = t[i];
        for (int i = 0; i < 9; i++) d[(i+3)*WORD_W +: WORD_W] = m[i];
        return d;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    // mostly near-rotation matrices: a signed permutation plus small noise
    function automatic logic [IN_W-1:0] rand_xform();
        logic [31:0] t[3];
        logic [31:0] m[9];
        int perm[3];
        int k, tmp;
        for (int i = 0; i < 3; i++) t[i] = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 9; i++) m[i] = rand_word();
        end else begin
            perm = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
            end
            for (int i = 0; i < 9; i++)
                m[i] = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            for (int i = 0; i < 3; i++)
                m[i*3 + perm[i]] += ($urandom_range(0, 1) ? 32'h2000_0000 : 32'hE000_0000);
        end
        return pack_xform(t, m);
    endfunction

    task automatic push_xform(logic [IN_W-1:0] d);
        xform_q.push_back(d);
        drain_q.push_back(1'b0);
    endtask

    task automatic push_diag(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] off);
        logic [31:0] t[3];
        logic [31:0] m[9];
        t = '{$urandom, $urandom, $urandom};
        m = '{a, off, -off, -off, b, off, off, -off, c};
        push_xform(pack_xform(t, m));
    endtask

    // directed part, then random transforms with a drain point in the middle
    initial begin
        logic [31:0] t[3];
        logic [31:0] m[9];
        push_diag(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 0);        // identity
        push_diag(32'h2000_0000, 32'hE000_0000, 32'hE000_0000, 0);        // x branch
        push_diag(32'hE000_0000, 32'h2000_0000, 32'hE000_0000, 0);        // y branch
        push_diag(32'hE000_0000, 32'hE000_0000, 32'h2000_0000, 0);        // z branch
        push_diag(32'hE000_0000, 32'hE000_0000, 32'hE000_0000, 32'h100);  // ties, z branch
        push_diag(0, 0, 0, 0);                                            // zero trace
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF); // ties, z branch, large S
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);        // zero num, large S
        push_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // max trace
        push_diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000); // huge x
        push_diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_diag(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        push_diag(32'hDFFF_FFFF, 32'hE000_0000, 32'h4000_0000, 32'h0000_0001); // z branch
        push_diag(32'hFFFF_FFFF, 0, 1, 32'h7FFF_FFFF);                     // trace zero
        t = '{32'hFFFF_FFFF, 0, 32'h8000_0000};
        m = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        push_xform(pack_xform(t, m));
        t = '{32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        push_xform(pack_xform(t, m));
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                xform_q.push_back('0);
                drain_q.push_back(1'b1);
            end
            push_xform(rand_xform());
        end
    end

    // reset
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: random gap per transfer, optional drain before continuing
    int gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pose_q.push_back(pose_of(s_tdata));
                n_sent++;
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (s_tvalid && !s_tready) begin
                // hold
            end else if (gap > 0) begin
                gap--;
                s_tvalid <= 1'b0;
            end else if (xform_q.size() == 0) begin
                s_tvalid <= 1'b0;
                stim_done = 1;
            end else if (drain_q[0]) begin
                s_tvalid <= 1'b0;
                if (pose_q.size() == 0 && !(s_tvalid && s_tready)) begin
                    void'(xform_q.pop_front());
                    void'(drain_q.pop_front());
                end
            end else begin
                s_tdata  <= xform_q.pop_front();
                void'(drain_q.pop_front());
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor: compare each pose transfer with the oldest prediction
    int stall = 0;
    always @(posedge aclk) begin
        pose_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = pose_t'(m_tdata);
                n_recv++;
                if (pose_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pose %h", $time, m_tdata);
                end else begin
                    want = pose_q.pop_front();
                    if (got.px !== want.px) begin errors++;
                        $display("%0t: pos_x exp %h got %h", $time, want.px, got.px); end
                    if (got.py !== want.py) begin errors++;
                        $display("%0t: pos_y exp %h got %h", $time, want.py, got.py); end
                    if (got.pz !== want.pz) begin errors++;
                        $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz); end
                    if (got.qx !== want.qx) begin errors++;
                        $display("%0t: quat_x exp %h got %h", $time, want.qx, got.qx); end
                    if (got.qy !== want.qy) begin errors++;
                        $display("%0t: quat_y exp %h got %h", $time, want.qy, got.qy); end
                    if (got.qz !== want.qz) begin errors++;
                        $display("%0t: quat_z exp %h got %h", $time, want.qz, got.qz); end
                    if (got.qw !== want.qw) begin errors++;
                        $display("%0t: quat_w exp %h got %h", $time, want.qw, got.qw); end
                end
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // end of run and watchdog
    int settle = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("Timeout after %0d cycles, %0d poses pending", cycles, pose_q.size());
            $display("Regression FAIL");
            $finish;
        end else if (stim_done && pose_q.size() == 0) begin
            settle++;
            if (settle > LATENCY + 20) begin
                $display("Sent %0d transforms, checked %0d poses", n_sent, n_recv);
                $display("Branches: trace %0d, x %0d, y %0d, z %0d", n_branch[COMP_W],
                         n_branch[COMP_X], n_branch[COMP_Y], n_branch[COMP_Z]);
                if (errors == 0) begin
                    $display("Regression PASS");
                end else begin
                    $display("Regression FAIL");
                end
                $finish;
            end
        end else begin
            settle = 0;
        end
    end

endmodule

[rotation_matrix_to_quaternion.f]
hw/rtl/rmq_pkg.sv
hw/rtl/rotation_matrix_to_quaternion.sv
sim/tb_rotation_matrix_to_quaternion.sv
